// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, with and without a reset qualifier. They compile
// to nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property check failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: property check failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/dsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Descriptor slot allocator package
// Field widths, codes and defaults shared by the allocator RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsa_pkg;

    // Fixed field widths.
    localparam int IDX_W    = 12;   // slot index and stack entry
    localparam int CAP_W    = 13;   // capacity register and fresh counter
    localparam int SB_W     = 11;   // slot size in bytes
    localparam int OFS_W    = 22;   // byte offset result
    localparam int STATUS_W = 2;
    localparam int OPC_W    = 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int DEF_MAX_SLOTS = 4096;

    localparam logic [CAP_W-1:0] CAPACITY_RST   = 13'd4096;
    localparam logic [SB_W-1:0]  SLOT_BYTES_RST = 11'd32;

    typedef enum logic [OPC_W-1:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAPACITY   = 2'd0,
        REG_SLOT_BYTES = 2'd1
    } t_cfg_reg;

endpackage

// ===== sv/descriptor_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// Descriptor slot allocator
// Fixed-size slot allocator: a LIFO free stack in block RAM backed by a bump
// counter for never-used slots, returning slot index and byte offset.
// ----------------------------------------------------------------------------
//
//  Channel    Handshake                        Payload
//  ---------  -------------------------------  ---------------------------------
//  request    start && !busy                   i_opcode, i_free_slot
//  result     o_result_valid (one-cycle pulse) o_status, o_slot_index,
//                                              o_byte_offset
//  config     i_cfg_valid && o_cfg_ready       i_cfg_index, i_cfg_data
//
//  A request is taken every cycle; busy is never raised. Each result passes the
//  stack RAM read and the stage one registers, then the index times slot size
//  multiplier into the output registers, so throughput is one transaction per
//  cycle. Reset is synchronous and active low; it clears the stack depth, the
//  fresh counter, the pipeline valids and the registers. The stack RAM itself
//  is not cleared. The receiver cannot stall results.
//
`timescale 1ns / 1ps

`include "assert_macros.svh"

module descriptor_slot_allocator #(
    parameter int MAX_SLOTS = dsa_pkg::DEF_MAX_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request transaction.
    input  logic                           start,
    output logic                           busy,
    input  logic [dsa_pkg::OPC_W-1:0]      i_opcode,
    input  logic [dsa_pkg::IDX_W-1:0]      i_free_slot,
    // Result transaction.
    output logic                           o_result_valid,
    output logic [dsa_pkg::STATUS_W-1:0]   o_status,
    output logic [dsa_pkg::IDX_W-1:0]      o_slot_index,
    output logic [dsa_pkg::OFS_W-1:0]      o_byte_offset,
    // Configuration write transaction.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dsa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import dsa_pkg::*;

    // Stack address width and depth counter width (the counter must hold
    // MAX_SLOTS itself). Capacity comparisons run at the wider of the depth
    // counter and the capacity register.
    localparam int AW    = $clog2(MAX_SLOTS);
    localparam int DW    = $clog2(MAX_SLOTS + 1);
    localparam int CW    = (DW > CAP_W) ? DW : CAP_W;
    localparam int PRD_W = CAP_W + SB_W;

    localparam logic [CW-1:0] MAX_SLOTS_CW = CW'(MAX_SLOTS);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted; indices beyond
    // the register list are dropped.
    // ------------------------------------------------------------------
    logic [CAP_W-1:0] r_capacity;
    logic [SB_W-1:0]  r_slot_bytes;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAPACITY_RST;
            r_slot_bytes <= SLOT_BYTES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_CAPACITY:   r_capacity   <= i_cfg_data[CAP_W-1:0];
                REG_SLOT_BYTES: r_slot_bytes <= i_cfg_data[SB_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request decode. The depth and fresh counters live in flip-flops, so
    // every decision is made in the cycle the request is taken. A push
    // writes the RAM at that edge and a pop reads it at that edge; since
    // only one request is taken per cycle, a pop that follows a push to the
    // same entry always sees the written data and no forwarding is needed.
    // ------------------------------------------------------------------
    logic [DW-1:0]    r_free_depth;
    logic [CAP_W-1:0] r_next_fresh;
    logic [DW-1:0]    n_free_depth;
    logic [CAP_W-1:0] n_next_fresh;

    logic             accept;
    logic [CW-1:0]    eff_cap;
    logic [CW-1:0]    depth_cw;
    logic [CW-1:0]    fresh_cw;
    logic             do_push;
    logic             do_pop;
    logic             do_fresh;
    t_status          req_status;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign depth_cw = CW'(r_free_depth);
    assign fresh_cw = CW'(r_next_fresh);
    assign eff_cap  = (CW'(r_capacity) < MAX_SLOTS_CW) ? CW'(r_capacity) : MAX_SLOTS_CW;

    always_comb begin
        do_push    = 1'b0;
        do_pop     = 1'b0;
        do_fresh   = 1'b0;
        req_status = ST_OK;
        if (i_opcode == OP_FREE) begin
            if (depth_cw < eff_cap) begin
                do_push = 1'b1;
            end else begin
                req_status = ST_OVERFLOW;
            end
        end else begin
            priority if (r_free_depth != '0) begin
                do_pop = 1'b1;
            end else if (fresh_cw < eff_cap) begin
                do_fresh = 1'b1;
            end else begin
                req_status = ST_FULL;
            end
        end
    end

    always_comb begin
        n_free_depth = r_free_depth;
        n_next_fresh = r_next_fresh;
        if (accept) begin
            if (do_push) begin
                n_free_depth = r_free_depth + DW'(1);
            end
            if (do_pop) begin
                n_free_depth = r_free_depth - DW'(1);
            end
            if (do_fresh) begin
                n_next_fresh = r_next_fresh + CAP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_depth <= '0;
            r_next_fresh <= '0;
        end else begin
            r_free_depth <= n_free_depth;
            r_next_fresh <= n_next_fresh;
        end
    end

    // ------------------------------------------------------------------
    // Free stack RAM: one write or one read per cycle, registered read.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] r_stack [MAX_SLOTS];
    logic [IDX_W-1:0] r_rd_data;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [DW-1:0]    depth_m1;

    assign depth_m1 = r_free_depth - DW'(1);
    assign wr_addr  = r_free_depth[AW-1:0];
    assign rd_addr  = depth_m1[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (accept && do_push) begin
            r_stack[wr_addr] <= i_free_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && do_pop) begin
            r_rd_data <= r_stack[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage one: decision registered alongside the RAM read.
    // ------------------------------------------------------------------
    logic             r_s1_valid;
    t_status          r_s1_status;
    logic             r_s1_pop;
    logic             r_s1_got;
    logic [CAP_W-1:0] r_s1_fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= req_status;
            r_s1_pop    <= do_pop;
            r_s1_got    <= do_pop || do_fresh;
            r_s1_fresh  <= r_next_fresh;
        end
    end

    // ------------------------------------------------------------------
    // Stage two: pick the index and scale it by the slot size. The offset
    // is the full product wrapped to the result width.
    // ------------------------------------------------------------------
    logic [CAP_W-1:0] s1_index;
    logic [PRD_W-1:0] s1_product;

    always_comb begin
        priority if (!r_s1_got) begin
            s1_index = '0;
        end else if (r_s1_pop) begin
            s1_index = CAP_W'(r_rd_data);
        end else begin
            s1_index = r_s1_fresh;
        end
    end

    assign s1_product = PRD_W'(s1_index) * PRD_W'(r_slot_bytes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            o_status      <= r_s1_status;
            o_slot_index  <= s1_index[IDX_W-1:0];
            o_byte_offset <= s1_product[OFS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Checks. The depth bound holds trivially while reset is asserted, so it
    // is checked only once reset has been released.
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_result_latency, i_clk, i_rst_n, o_result_valid |-> $past(accept, 2))
    `ASSERT_ALWAYS(a_depth_bound, i_clk, !i_rst_n || (CW'(r_free_depth) <= MAX_SLOTS_CW))
    `ASSERT_CLK(a_fail_zero, i_clk, i_rst_n,
        (o_result_valid && o_status != ST_OK) |-> (o_slot_index == '0 && o_byte_offset == '0))
    `ASSERT_CLK(a_fresh_step, i_clk, i_rst_n,
        (accept && do_fresh) |=> (r_next_fresh == $past(r_next_fresh) + CAP_W'(1)))

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Descriptor slot allocator testbench
// Drives allocate and free transactions into the allocator, keeps its own
// copy of the free stack, the fresh-slot counter and both registers, and
// checks every result strobe field by field against the answer worked out
// when the request was taken. Capacity and slot size are rewritten between
// phases, including zero, one, the full table and values beyond it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import dsa_pkg::*;

    localparam int SLOTS        = DEF_MAX_SLOTS;
    localparam int RANDOM_ITEMS = 850;
    // The longest quiet stretch in a correct run is a full request gap plus
    // the pipeline and a drain; this is many times that.
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_PRINTED  = 40;

    // How the request side spaces its transactions within one phase.
    typedef enum int {
        PACE_BACK_TO_BACK,
        PACE_UNIFORM,
        PACE_SPARSE
    } t_pacing;

    typedef struct {
        t_opcode          op;
        logic [IDX_W-1:0] slot;
        int               gap;    // idle cycles before the request is offered
        bit               drain;  // hold off until every answer has come back
    } t_request;

    typedef struct {
        t_status          status;
        logic [IDX_W-1:0] index;
        logic [OFS_W-1:0] offset;
    } t_answer;

    // ------------------------------------------------------------------
    // Block ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [OPC_W-1:0]      i_opcode    = OP_ALLOC;
    logic [IDX_W-1:0]      i_free_slot = '0;
    logic                  o_result_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [IDX_W-1:0]      o_slot_index;
    logic [OFS_W-1:0]      o_byte_offset;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_CAPACITY;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    descriptor_slot_allocator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_free_slot    (i_free_slot),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index),
        .o_byte_offset  (o_byte_offset),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow state of the allocator. It starts at the reset values, and
    // since reset is applied only once it never needs clearing again.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] recycled [SLOTS];
    int               recycled_depth = 0;
    int               fresh_next     = 0;
    logic [CAP_W-1:0] cap_setting    = CAPACITY_RST;
    logic [SB_W-1:0]  size_setting   = SLOT_BYTES_RST;

    t_request requests_queued[$];
    t_answer  answers_due[$];
    t_pacing  pacing = PACE_UNIFORM;
    int       mismatches = 0;

    // Applies one request to the shadow state and returns the answer the
    // block must give. An allocate prefers the most recently freed slot,
    // then a never-used one, and otherwise reports the table as full. The
    // capacity register is clipped to the depth of the stack.
    function automatic t_answer slot_answer(t_opcode op, logic [IDX_W-1:0] slot);
        t_answer                ans;
        int                     usable;
        bit                     granted;
        logic [IDX_W+SB_W-1:0]  product;
        usable     = (cap_setting < SLOTS) ? int'(cap_setting) : SLOTS;
        ans.status = ST_OK;
        ans.index  = '0;
        ans.offset = '0;
        granted    = 1'b0;
        if (op == OP_ALLOC) begin
            if (recycled_depth > 0) begin
                recycled_depth--;
                ans.index = recycled[recycled_depth];
                granted   = 1'b1;
            end else if (fresh_next < usable) begin
                ans.index = IDX_W'(fresh_next);
                fresh_next++;
                granted   = 1'b1;
            end else begin
                ans.status = ST_FULL;
            end
        end else if (recycled_depth < usable) begin
            // Any index is accepted, duplicates and out-of-range ones alike.
            recycled[recycled_depth] = slot;
            recycled_depth++;
        end else begin
            ans.status = ST_OVERFLOW;
        end
        if (granted) begin
            // The offset keeps only its low bits when the product is too wide.
            product    = ans.index * size_setting;
            ans.offset = product[OFS_W-1:0];
        end
        return ans;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic void queue_request(t_opcode op, logic [IDX_W-1:0] slot);
        t_request req;
        req.op   = op;
        req.slot = slot;
        case (pacing)
            PACE_BACK_TO_BACK: req.gap = 0;
            PACE_UNIFORM:      req.gap = $urandom_range(0, 11);
            default:           req.gap = ($urandom_range(0, 3) == 0) ?
                                         $urandom_range(0, 11) : 0;
        endcase
        req.drain = ($urandom_range(0, 39) == 0);
        requests_queued.push_back(req);
    endfunction

    // ------------------------------------------------------------------
    // Request driver. The answer is worked out at the edge where the
    // transaction is taken, so the shadow state advances in the same order
    // as the block's own. A request that is not yet taken is held as it is.
    // ------------------------------------------------------------------
    int gap_count = 0;

    always @(posedge i_clk) begin
        bit       taken;
        t_request req;
        taken = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_count = 0;
        end else begin
            if (taken) begin
                answers_due.push_back(slot_answer(t_opcode'(i_opcode), i_free_slot));
            end
            if (start && !taken) begin
                // Stalled by the block: keep the request on the ports.
            end else if (requests_queued.size() == 0) begin
                start <= 1'b0;
            end else if (gap_count < requests_queued[0].gap) begin
                gap_count++;
                start       <= 1'b0;
                i_free_slot <= IDX_W'($urandom);   // noise while nothing is offered
            end else if (requests_queued[0].drain && answers_due.size() != 0) begin
                start <= 1'b0;
            end else begin
                req = requests_queued.pop_front();
                gap_count = 0;
                start       <= 1'b1;
                i_opcode    <= req.op;
                i_free_slot <= req.slot;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Each strobe is matched against the oldest answer
    // outstanding. An unknown strobe is treated as a result so that it
    // cannot slip past unnoticed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_answer due;
        if (i_rst_n && o_result_valid !== 1'b0) begin
            if (answers_due.size() == 0) begin
                report_mismatch("result strobe with no request outstanding");
            end else begin
                due = answers_due.pop_front();
                if (o_status !== due.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, due.status));
                end
                if (o_slot_index !== due.index) begin
                    report_mismatch($sformatf("slot index %0d, expected %0d",
                                              o_slot_index, due.index));
                end
                if (o_byte_offset !== due.offset) begin
                    report_mismatch($sformatf("byte offset %0d, expected %0d",
                                              o_byte_offset, due.offset));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if no transaction of any kind completes for
    // too long.
    // ------------------------------------------------------------------
    int stalled = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid === 1'b1 ||
            (i_cfg_valid && o_cfg_ready)) begin
            stalled = 0;
        end else begin
            stalled++;
        end
        if (stalled >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // A register write is only ever issued while the block is idle, so the
    // shadow copy can be updated as soon as the transaction completes.
    task automatic write_register(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        if (idx == REG_CAPACITY) begin
            cap_setting = data[CAP_W-1:0];
        end else begin
            size_setting = data[SB_W-1:0];
        end
    endtask

    // Idle means every request has been taken and answered. Sampling on the
    // falling edge keeps clear of the updates made at the rising one.
    task automatic wait_idle();
        while (requests_queued.size() != 0 || start || answers_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus: a directed opening, then random phases, each with its own
    // register settings, pacing and mix of allocates and frees.
    // ------------------------------------------------------------------
    initial begin
        int                    produced;
        int                    count;
        int                    alloc_pct;
        logic [CAP_W-1:0]      cap_value;
        logic [SB_W-1:0]       size_value;
        logic [IDX_W-1:0]      slot;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A single slot with the widest slot size: the one fresh slot, then
        // table full, a stack that overflows after one entry, a recycled top
        // index whose offset wraps, and table full once more.
        write_register(REG_CAPACITY, 13'd1);
        write_register(REG_SLOT_BYTES, 13'd2047);
        queue_request(OP_ALLOC, IDX_W'($urandom));
        queue_request(OP_ALLOC, IDX_W'($urandom));
        queue_request(OP_FREE, 12'hFFF);
        queue_request(OP_FREE, 12'h000);
        queue_request(OP_ALLOC, IDX_W'($urandom));
        queue_request(OP_ALLOC, IDX_W'($urandom));
        wait_idle();

        // Zero capacity: nothing fresh is handed out and every free overflows.
        write_register(REG_CAPACITY, 13'd0);
        queue_request(OP_ALLOC, IDX_W'($urandom));
        queue_request(OP_FREE, 12'hAAA);
        wait_idle();

        // Capacity beyond the stack depth is clipped; the slot size write
        // carries set bits above the register, which must be dropped.
        pacing = PACE_BACK_TO_BACK;
        write_register(REG_CAPACITY, '1);
        write_register(REG_SLOT_BYTES, 13'h1801);
        queue_request(OP_FREE, 12'hAAA);
        queue_request(OP_FREE, 12'h555);
        queue_request(OP_ALLOC, IDX_W'($urandom));
        queue_request(OP_ALLOC, IDX_W'($urandom));
        queue_request(OP_ALLOC, IDX_W'($urandom));
        queue_request(OP_ALLOC, IDX_W'($urandom));
        queue_request(OP_FREE, 12'hFFF);
        queue_request(OP_FREE, 12'h000);
        queue_request(OP_ALLOC, IDX_W'($urandom));
        queue_request(OP_ALLOC, IDX_W'($urandom));

        produced = 0;
        while (produced < RANDOM_ITEMS) begin
            wait_idle();

            // Capacity mostly sits just above the slots already handed out,
            // so the fresh counter runs dry; sometimes it drops below them.
            case ($urandom_range(0, 9))
                0:       cap_value = '0;
                1:       cap_value = 13'd1;
                2:       cap_value = CAP_W'(SLOTS);
                3:       cap_value = '1;
                4:       cap_value = CAP_W'($urandom);
                5:       cap_value = (fresh_next > 4) ?
                                     CAP_W'(fresh_next - $urandom_range(1, 4)) :
                                     CAP_W'(fresh_next);
                default: cap_value = CAP_W'(fresh_next + $urandom_range(0, 12));
            endcase
            case ($urandom_range(0, 7))
                0:       size_value = '0;
                1:       size_value = 11'd1;
                2:       size_value = 11'd1024;
                3:       size_value = '1;
                default: size_value = SB_W'($urandom_range(1, 1024));
            endcase
            if ($urandom_range(0, 3) != 0) begin
                write_register(REG_CAPACITY, cap_value);
            end
            if ($urandom_range(0, 1) != 0) begin
                write_register(REG_SLOT_BYTES, {2'($urandom), size_value});
            end

            pacing    = t_pacing'($urandom_range(0, 2));
            alloc_pct = 25 * $urandom_range(1, 3);
            count     = $urandom_range(15, 60);
            for (int n = 0; n < count; n++) begin
                if ($urandom_range(1, 100) <= alloc_pct) begin
                    queue_request(OP_ALLOC, IDX_W'($urandom));
                end else begin
                    case ($urandom_range(0, 7))
                        0:       slot = '0;
                        1:       slot = '1;
                        default: slot = IDX_W'($urandom);
                    endcase
                    queue_request(OP_FREE, slot);
                end
            end
            produced += count;
        end

        wait_idle();
        // Give a stray late strobe the chance to show itself.
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
